// File: hdl/packbits_rle_encoder_macros.svh
// Assertion macros shared by the encoder modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PACKBITS_RLE_ENCODER_MACROS_SVH
`define PACKBITS_RLE_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBRLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define PBRLE_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// File: hdl/pbrle_pkg.sv
package pbrle_pkg;

  // PackBits limits.
  localparam int RUN_MIN  = 3;
  localparam int RUN_MAX  = 128 + RUN_MIN - 1;
  localparam int COPY_MAX = 128;
  localparam int READ_MAX = COPY_MAX + RUN_MIN - 1;

  // Literal byte ring: pending and committed literal bytes live here.
  localparam int RING_AW    = 8;
  localparam int RING_DEPTH = 1 << RING_AW;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [RING_AW-1:0] ring_addr_t;

  // One encoding command: a literal block read from the ring, or a run.
  // For a literal, data is the start address in the ring; for a run it is
  // the repeated byte.
  typedef struct packed {
    logic       is_lit;
    logic [7:0] hdr;
    ring_addr_t data;
    logic [7:0] len;
    logic       end_item;
    logic       end_stream;
  } cmd_t;

  // Write port of the literal ring.
  typedef struct packed {
    logic       en;
    ring_addr_t addr;
    logic [7:0] data;
  } mem_wr_t;

  // One encoded byte on its way to the word packer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       end_item;
    logic       end_stream;
  } enc_byte_t;

endpackage

// File: hdl/pbrle_cmd_fifo.sv
`include "packbits_rle_encoder_macros.svh"

module pbrle_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbrle_pkg::cmd_t   din,
  input  logic              pop,
  output pbrle_pkg::cmd_t   head,
  output logic              empty,
  output logic              afull
);

  localparam int AW    = pbrle_pkg::Q_AW;
  localparam int CW    = pbrle_pkg::Q_CW;
  localparam int DEPTH = pbrle_pkg::Q_DEPTH;

  pbrle_pkg::cmd_t entries_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  // Status toward the front and the back.
  assign head  = entries_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign afull = (cnt_r >= CW'(DEPTH - 1));

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

  `PBRLE_ASSERT_IMP(a_no_overflow, push, cnt_r != CW'(DEPTH), "command queue overflow")
  `PBRLE_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0, "command queue underflow")

endmodule

// File: hdl/pbrle_front.sv
`include "packbits_rle_encoder_macros.svh"

module pbrle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 push,
  output logic                 full,
  input  logic                 q_afull,
  output logic                 q_push,
  output pbrle_pkg::cmd_t      q_din,
  output pbrle_pkg::mem_wr_t   mem_wr,
  input  logic                 rd_release
);

  localparam int AW = pbrle_pkg::RING_AW;

  // Encoder state.
  logic [7:0]      count_r, count_nxt;
  logic            in_run_r, in_run_nxt;
  logic [7:0]      run_val_r, run_val_nxt;
  logic [7:0]      run_len_r, run_len_nxt;
  logic [7:0]      prev1_r, prev1_nxt;
  logic [7:0]      prev2_r, prev2_nxt;
  logic [AW-1:0]   pstart_r, pstart_nxt;
  logic [AW:0]     inflight_r, inflight_nxt;
  logic            b_pend_r;
  pbrle_pkg::cmd_t b_cmd_r;

  logic            accept;
  logic            wr_byte;
  logic            a_vld, b_vld;
  pbrle_pkg::cmd_t a_cmd, b_cmd;
  logic [AW:0]     lit_add;
  logic [AW+1:0]   ring_used;
  logic [AW-1:0]   wptr;
  logic [7:0]      n1;
  logic [7:0]      len1;
  logic            run_hit;

  function automatic pbrle_pkg::cmd_t lit_cmd(input logic [AW-1:0] start,
                                              input logic [7:0] len);
    pbrle_pkg::cmd_t c;
    c        = '0;
    c.is_lit = 1'b1;
    c.hdr    = len - 8'd1;
    c.data   = start;
    c.len    = len;
    return c;
  endfunction

  function automatic pbrle_pkg::cmd_t run_cmd(input logic [7:0] len,
                                              input logic [7:0] value);
    pbrle_pkg::cmd_t c;
    c      = '0;
    c.hdr  = 8'(pbrle_pkg::RUN_MIN - 1) - len;
    c.data = value;
    return c;
  endfunction

  // Ring occupancy: committed but unread literal bytes plus pending ones.
  assign ring_used = {1'b0, inflight_r} + {2'b0, count_r};
  assign full      = b_pend_r || q_afull || (ring_used >= (AW + 2)'(pbrle_pkg::RING_DEPTH));
  assign accept    = push && !full;

  assign wptr    = pstart_r + count_r;
  assign n1      = count_r + 8'd1;
  assign len1    = run_len_r + 8'd1;
  assign run_hit = (count_r >= 8'd2) && (prev1_r == in_byte) && (prev2_r == in_byte);

  // Classify the incoming byte and form up to two commands.
  always_comb begin
    count_nxt   = count_r;
    in_run_nxt  = in_run_r;
    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    prev1_nxt   = prev1_r;
    prev2_nxt   = prev2_r;
    pstart_nxt  = pstart_r;
    wr_byte     = 1'b0;
    a_vld       = 1'b0;
    a_cmd       = '0;
    b_vld       = 1'b0;
    b_cmd       = '0;

    if (in_run_r) begin
      if (in_byte == run_val_r) begin
        if (len1 == 8'(pbrle_pkg::RUN_MAX)) begin
          // Maximum run: send it now and start over with an empty buffer.
          a_vld       = 1'b1;
          a_cmd       = run_cmd(len1, run_val_r);
          in_run_nxt  = 1'b0;
          run_len_nxt = '0;
          count_nxt   = '0;
        end else begin
          run_len_nxt = len1;
          if (in_last) begin
            a_vld = 1'b1;
            a_cmd = run_cmd(len1, run_val_r);
          end
        end
      end else begin
        // Run breaker: send the run and open a new literal buffer with it.
        a_vld       = 1'b1;
        a_cmd       = run_cmd(run_len_r, run_val_r);
        in_run_nxt  = 1'b0;
        run_len_nxt = '0;
        wr_byte     = 1'b1;
        count_nxt   = 8'd1;
        prev1_nxt   = in_byte;
        if (in_last) begin
          b_vld = 1'b1;
          b_cmd = lit_cmd(wptr, 8'd1);
        end
      end
    end else begin
      wr_byte   = 1'b1;
      prev1_nxt = in_byte;
      prev2_nxt = prev1_r;
      if (run_hit) begin
        // Three equal bytes: literals before them go out, a run begins.
        in_run_nxt  = 1'b1;
        run_val_nxt = in_byte;
        run_len_nxt = 8'(pbrle_pkg::RUN_MIN);
        count_nxt   = '0;
        pstart_nxt  = pstart_r + AW'(count_r - 8'd2);
        if (count_r > 8'd2) begin
          a_vld = 1'b1;
          a_cmd = lit_cmd(pstart_r, count_r - 8'd2);
          if (in_last) begin
            b_vld = 1'b1;
            b_cmd = run_cmd(8'(pbrle_pkg::RUN_MIN), in_byte);
          end
        end else if (in_last) begin
          a_vld = 1'b1;
          a_cmd = run_cmd(8'(pbrle_pkg::RUN_MIN), in_byte);
        end
      end else if (n1 == 8'(pbrle_pkg::READ_MAX)) begin
        // Full buffer: send the first block, the last two bytes stay.
        a_vld      = 1'b1;
        a_cmd      = lit_cmd(pstart_r, 8'(pbrle_pkg::COPY_MAX));
        pstart_nxt = pstart_r + AW'(pbrle_pkg::COPY_MAX);
        count_nxt  = 8'(pbrle_pkg::READ_MAX - pbrle_pkg::COPY_MAX);
        if (in_last) begin
          b_vld = 1'b1;
          b_cmd = lit_cmd(pstart_nxt, count_nxt);
        end
      end else begin
        count_nxt = n1;
        if (in_last) begin
          a_vld = 1'b1;
          if (n1 > 8'(pbrle_pkg::COPY_MAX)) begin
            a_cmd = lit_cmd(pstart_r, 8'(pbrle_pkg::COPY_MAX));
            b_vld = 1'b1;
            b_cmd = lit_cmd(pstart_r + AW'(pbrle_pkg::COPY_MAX),
                            n1 - 8'(pbrle_pkg::COPY_MAX));
          end else begin
            a_cmd = lit_cmd(pstart_r, n1);
          end
        end
      end
    end

    // End of stream: everything pending has been committed above.
    if (in_last) begin
      pstart_nxt  = pstart_nxt + count_nxt;
      count_nxt   = '0;
      in_run_nxt  = 1'b0;
      run_val_nxt = '0;
      run_len_nxt = '0;
    end

    // The final command of this transaction closes the item.
    if (b_vld) begin
      b_cmd.end_item   = 1'b1;
      b_cmd.end_stream = in_last;
    end else if (a_vld) begin
      a_cmd.end_item   = 1'b1;
      a_cmd.end_stream = in_last;
    end
  end

  // Literal bytes newly referenced by commands of this transaction.
  always_comb begin
    lit_add = '0;
    if (a_vld && a_cmd.is_lit) begin
      lit_add = lit_add + {1'b0, a_cmd.len};
    end
    if (b_vld && b_cmd.is_lit) begin
      lit_add = lit_add + {1'b0, b_cmd.len};
    end
    inflight_nxt = inflight_r + (accept ? lit_add : '0) - {{AW{1'b0}}, rd_release};
  end

  // Queue and ring write ports.
  assign q_push      = (accept && a_vld) || b_pend_r;
  assign q_din       = b_pend_r ? b_cmd_r : a_cmd;
  assign mem_wr.en   = accept && wr_byte;
  assign mem_wr.addr = wptr;
  assign mem_wr.data = in_byte;

  // State update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      in_run_r   <= 1'b0;
      run_val_r  <= '0;
      run_len_r  <= '0;
      pstart_r   <= '0;
      inflight_r <= '0;
      b_pend_r   <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
      b_pend_r   <= accept && b_vld;
      if (accept) begin
        count_r   <= count_nxt;
        in_run_r  <= in_run_nxt;
        run_val_r <= run_val_nxt;
        run_len_r <= run_len_nxt;
        pstart_r  <= pstart_nxt;
      end
    end
  end

  // Look-back bytes and the deferred second command.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev1_r <= prev1_nxt;
      prev2_r <= prev2_nxt;
      b_cmd_r <= b_cmd;
    end
  end

  `PBRLE_ASSERT_HOLDS(a_ring_bound, ring_used <= (AW + 2)'(pbrle_pkg::RING_DEPTH), "literal ring over-committed")

endmodule

// File: hdl/pbrle_back.sv
module pbrle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  pbrle_pkg::cmd_t        q_head,
  output logic                   q_pop,
  input  pbrle_pkg::mem_wr_t     mem_wr,
  output logic                   rd_release,
  output pbrle_pkg::enc_byte_t   enc,
  input  logic                   enc_rdy
);

  localparam int AW = pbrle_pkg::RING_AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_BODY
  } state_t;

  state_t          st_r, st_nxt;
  pbrle_pkg::cmd_t cmd_r;
  logic [7:0]      left_r;
  logic [AW-1:0]   ptr_r;
  logic [7:0]      rdata_r;
  logic [7:0]      ring_mem [pbrle_pkg::RING_DEPTH];

  logic            fire;
  logic            final_byte;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  // Byte presented to the packer.
  assign final_byte     = (st_r == S_BODY) && (left_r == 8'd1);
  assign enc.vld        = (st_r != S_IDLE);
  assign enc.data       = (st_r == S_HDR) ? cmd_r.hdr : (cmd_r.is_lit ? rdata_r : cmd_r.data);
  assign enc.end_item   = final_byte && cmd_r.end_item;
  assign enc.end_stream = final_byte && cmd_r.end_stream;
  assign fire           = enc.vld && enc_rdy;

  // Literal reads run one byte ahead of the byte being sent.
  assign rd_en      = fire && cmd_r.is_lit && ((st_r == S_HDR) || ((st_r == S_BODY) && !final_byte));
  assign rd_addr    = (st_r == S_HDR) ? cmd_r.data : ptr_r;
  assign rd_release = rd_en;

  // Next command is taken when idle or as the current one finishes.
  assign q_pop = !q_empty && ((st_r == S_IDLE) || (fire && final_byte));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_pop) st_nxt = S_HDR;
      end
      S_HDR: begin
        if (fire) st_nxt = S_BODY;
      end
      S_BODY: begin
        if (fire && final_byte) st_nxt = q_pop ? S_HDR : S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Sequencer state and command registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (fire && (st_r == S_HDR)) begin
      left_r <= cmd_r.is_lit ? cmd_r.len : 8'd1;
      ptr_r  <= cmd_r.data + AW'(1);
    end else if (fire && (st_r == S_BODY)) begin
      left_r <= left_r - 8'd1;
      if (rd_en) begin
        ptr_r <= ptr_r + AW'(1);
      end
    end
  end

  // Literal ring: one write port from the front, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      ring_mem[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

endmodule

// File: hdl/pbrle_packer.sv
`include "packbits_rle_encoder_macros.svh"

module pbrle_packer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pbrle_pkg::enc_byte_t   enc,
  output logic                   enc_rdy,
  output logic [7:0]             out_byte0,
  output logic [7:0]             out_byte1,
  output logic [7:0]             out_byte2,
  output logic [7:0]             out_byte3,
  output logic [2:0]             out_count,
  output logic                   out_item_end,
  output logic                   out_stream_end,
  output logic                   empty,
  input  logic                   pop
);

  logic [7:0] acc_r [3];
  logic [1:0] acc_n_r;
  logic [7:0] word [4];
  logic [7:0] out_b_r [4];
  logic [2:0] out_cnt_r;
  logic       out_item_r;
  logic       out_stream_r;
  logic       out_vld_r;

  logic       completes;
  logic       take;
  logic       load;

  // A word closes at four bytes or at the end of a transaction's output.
  assign completes = enc.end_item || (acc_n_r == 2'd3);
  assign enc_rdy   = !completes || !out_vld_r || pop;
  assign take      = enc.vld && enc_rdy;
  assign load      = take && completes;

  // Closing word: collected bytes, the new byte, zeros beyond the count.
  always_comb begin
    word[0] = (acc_n_r == 2'd0) ? enc.data : acc_r[0];
    word[1] = (acc_n_r == 2'd1) ? enc.data : ((acc_n_r > 2'd1) ? acc_r[1] : 8'd0);
    word[2] = (acc_n_r == 2'd2) ? enc.data : ((acc_n_r > 2'd2) ? acc_r[2] : 8'd0);
    word[3] = (acc_n_r == 2'd3) ? enc.data : 8'd0;
  end

  // Output register and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      acc_n_r   <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      if (take) begin
        acc_n_r <= completes ? 2'd0 : acc_n_r + 2'd1;
      end
    end
  end

  // Byte lanes.
  always_ff @(posedge clk) begin
    if (take && !completes) begin
      acc_r[acc_n_r] <= enc.data;
    end
    if (load) begin
      out_b_r      <= word;
      out_cnt_r    <= {1'b0, acc_n_r} + 3'd1;
      out_item_r   <= enc.end_item;
      out_stream_r <= enc.end_stream;
    end
  end

  assign out_byte0      = out_b_r[0];
  assign out_byte1      = out_b_r[1];
  assign out_byte2      = out_b_r[2];
  assign out_byte3      = out_b_r[3];
  assign out_count      = out_cnt_r;
  assign out_item_end   = out_item_r;
  assign out_stream_end = out_stream_r;
  assign empty          = !out_vld_r;

  `PBRLE_ASSERT_IMP(a_short_word_ends_item, out_vld_r && !out_item_r, out_cnt_r == 3'd4, "short word before item end")
  `PBRLE_ASSERT_IMP(a_stream_end_in_item_end, out_vld_r && out_stream_r, out_item_r, "stream end without item end")

endmodule

// File: hdl/packbits_rle_encoder.sv
// PackBits run-length encoder, one raw byte per input transaction.
// Input: drive in_byte and in_last with push; a transaction completes on a
// clock edge with push high and full low. in_last marks the final byte of a
// stream; pending literals or the open run are flushed and the run and
// literal-count state returns to its reset values.
// Output: encoded bytes come packed in words of one to four bytes. While
// empty is low, out_byte0..out_byte3, out_count, out_item_end and
// out_stream_end show the oldest word; pop with empty low takes it.
// out_item_end marks the last word caused by one input byte, out_stream_end
// the last word of the stream. A byte that causes no output gives no word.
// The back end sends one encoded byte per cycle while the packer accepts,
// from the single read port of the literal ring, and idles between commands
// when the queue runs dry. A run is a header and one byte, a literal block of
// L bytes a header and L bytes. The front takes one byte per cycle but holds
// full while it queues a byte's second command, while the 4-entry command
// queue is nearly full or while the 256-entry literal ring has no room. Reset
// clears the state. A stalled receiver holds the output word; up to three
// more bytes gather behind it, then the back end, the queue and finally the
// input stall.
module packbits_rle_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] out_count,
  output logic       out_item_end,
  output logic       out_stream_end,
  output logic       empty,
  input  logic       pop
);

  logic                 q_push;
  pbrle_pkg::cmd_t      q_din;
  logic                 q_pop;
  pbrle_pkg::cmd_t      q_head;
  logic                 q_empty;
  logic                 q_afull;
  pbrle_pkg::mem_wr_t   mem_wr;
  logic                 rd_release;
  pbrle_pkg::enc_byte_t enc;
  logic                 enc_rdy;

  // Classifies bytes and writes literals into the ring.
  pbrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push       (push),
    .full       (full),
    .q_afull    (q_afull),
    .q_push     (q_push),
    .q_din      (q_din),
    .mem_wr     (mem_wr),
    .rd_release (rd_release)
  );

  // Command queue decoupling classification from byte emission.
  pbrle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .afull (q_afull)
  );

  // Turns commands into encoded bytes.
  pbrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .mem_wr     (mem_wr),
    .rd_release (rd_release),
    .enc        (enc),
    .enc_rdy    (enc_rdy)
  );

  // Packs encoded bytes into output words.
  pbrle_packer u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .enc            (enc),
    .enc_rdy        (enc_rdy),
    .out_byte0      (out_byte0),
    .out_byte1      (out_byte1),
    .out_byte2      (out_byte2),
    .out_byte3      (out_byte3),
    .out_count      (out_count),
    .out_item_end   (out_item_end),
    .out_stream_end (out_stream_end),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
